[sv/apfs_pkg.sv]
`timescale 1ns / 1ps

package apfs_pkg;

  localparam int unsigned BEEP_TICKS  = 100;
  localparam int unsigned BEEP_W      = 7;
  localparam int unsigned RUN_W       = 20;
  localparam int unsigned PHASE_W     = 17;
  localparam int unsigned CYCLE_W     = 8;
  localparam int unsigned MS_W        = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
  localparam logic [CYCLE_W-1:0] CYCLE_MAX = {CYCLE_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_CAL     = 2'd1,
    MODE_FIRE    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_CAL     = 2'd1,
    REQ_FIRE    = 2'd2,
    REQ_STANDBY = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARMED        = 3'd0,
    CFG_LEFT_ENABLE  = 3'd1,
    CFG_RIGHT_ENABLE = 3'd2,
    CFG_FIRE_TIMEOUT = 3'd3,
    CFG_CYCLE_LIMIT  = 3'd4,
    CFG_CAL_TIMEOUT  = 3'd5,
    CFG_PULSE_MS     = 3'd6,
    CFG_PAUSE_MS     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       trigger_low;
  } in_t;

  typedef struct packed {
    logic       left_gun;
    logic       right_gun;
    logic       gun_power;
    logic       buzzer_on;
    logic       armed_led;
    logic       activation_done;
    logic [1:0] mode_now;
  } out_t;

  typedef struct packed {
    logic               armed;
    logic               left_enable;
    logic               right_enable;
    logic [RUN_W-1:0]   firing_timeout_ms;
    logic [CYCLE_W-1:0] firing_cycle_limit;
    logic [RUN_W-1:0]   calibration_timeout_ms;
    logic [MS_W-1:0]    pulse_ms;
    logic [MS_W-1:0]    pause_ms;
  } cfg_t;

endpackage

[sv/apfs_cfg.sv]
`timescale 1ns / 1ps

module apfs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [apfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output apfs_pkg::cfg_t                     cfg
);
  import apfs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ARMED:        cfg_nxt.armed                  = cfg_wdata[0];
        CFG_LEFT_ENABLE:  cfg_nxt.left_enable            = cfg_wdata[0];
        CFG_RIGHT_ENABLE: cfg_nxt.right_enable           = cfg_wdata[0];
        CFG_FIRE_TIMEOUT: cfg_nxt.firing_timeout_ms      = cfg_wdata[RUN_W-1:0];
        CFG_CYCLE_LIMIT:  cfg_nxt.firing_cycle_limit     = cfg_wdata[CYCLE_W-1:0];
        CFG_CAL_TIMEOUT:  cfg_nxt.calibration_timeout_ms = cfg_wdata[RUN_W-1:0];
        CFG_PULSE_MS:     cfg_nxt.pulse_ms               = cfg_wdata[MS_W-1:0];
        CFG_PAUSE_MS:     cfg_nxt.pause_ms               = cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.armed                  <= 1'b0;
      cfg_r.left_enable            <= 1'b1;
      cfg_r.right_enable           <= 1'b1;
      cfg_r.firing_timeout_ms      <= RUN_W'(10000);
      cfg_r.firing_cycle_limit     <= CYCLE_W'(8);
      cfg_r.calibration_timeout_ms <= RUN_W'(30000);
      cfg_r.pulse_ms               <= MS_W'(250);
      cfg_r.pause_ms               <= MS_W'(250);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/apfs_core.sv]
`timescale 1ns / 1ps

module apfs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  apfs_pkg::cfg_t cfg,
  input  logic           step,
  input  apfs_pkg::in_t  item,
  output apfs_pkg::out_t res
);
  import apfs_pkg::*;

  mode_t               mode_r,      mode_nxt;
  logic [RUN_W-1:0]    run_r,       run_nxt;
  logic [PHASE_W-1:0]  phase_r,     phase_nxt;
  logic [CYCLE_W-1:0]  cycle_r,     cycle_nxt;
  logic                left_turn_r, left_turn_nxt;
  logic [BEEP_W-1:0]   beep_r,      beep_nxt;

  mode_t               mode_req;
  logic                cal_end;
  logic                fire_abort;
  logic                fire_end;
  logic                fire_run;
  logic                in_pulse;
  logic [PHASE_W-1:0]  phase_len;
  req_t                req;

  assign req       = req_t'(item.req_type);
  assign phase_len = {1'b0, cfg.pulse_ms} + {1'b0, cfg.pause_ms};

  // next state
  always_comb begin
    beep_nxt      = (beep_r != '0) ? beep_r - 1'b1 : beep_r;
    mode_req      = mode_r;
    run_nxt       = run_r;
    phase_nxt     = phase_r;
    cycle_nxt     = cycle_r;
    left_turn_nxt = left_turn_r;
    cal_end       = 1'b0;
    fire_abort    = 1'b0;
    fire_end      = 1'b0;
    fire_run      = 1'b0;
    in_pulse      = 1'b0;

    if (req == REQ_CAL && mode_r != MODE_CAL) begin
      mode_req = MODE_CAL;
      run_nxt  = '0;
    end else if (req == REQ_FIRE && mode_r != MODE_FIRE) begin
      mode_req      = MODE_FIRE;
      run_nxt       = '0;
      phase_nxt     = '0;
      cycle_nxt     = '0;
      left_turn_nxt = cfg.left_enable;
    end else if (req == REQ_STANDBY) begin
      mode_req = MODE_STANDBY;
    end

    mode_nxt = MODE_STANDBY;
    case (mode_req)
      MODE_CAL: begin
        if (item.trigger_low || run_nxt >= cfg.calibration_timeout_ms) begin
          cal_end  = 1'b1;
          beep_nxt = BEEP_W'(BEEP_TICKS);
        end else begin
          mode_nxt = MODE_CAL;
          if (run_nxt != RUN_MAX) run_nxt = run_nxt + 1'b1;
        end
      end
      MODE_FIRE: begin
        if (!cfg.armed || (!cfg.left_enable && !cfg.right_enable)) begin
          fire_abort = 1'b1;
        end else if (item.trigger_low || run_nxt >= cfg.firing_timeout_ms ||
                     cycle_nxt >= cfg.firing_cycle_limit) begin
          fire_end = 1'b1;
        end else begin
          mode_nxt = MODE_FIRE;
          fire_run = 1'b1;
          if (run_nxt != RUN_MAX) run_nxt = run_nxt + 1'b1;
          if (phase_nxt < {1'b0, cfg.pulse_ms}) begin
            in_pulse = 1'b1;
            if (phase_nxt != PHASE_MAX) phase_nxt = phase_nxt + 1'b1;
          end else if (phase_nxt < phase_len) begin
            if (phase_nxt != PHASE_MAX) phase_nxt = phase_nxt + 1'b1;
          end else begin
            if (cycle_nxt != CYCLE_MAX) cycle_nxt = cycle_nxt + 1'b1;
            left_turn_nxt = ~left_turn_nxt;
            phase_nxt     = PHASE_W'(1);
          end
        end
      end
      default: mode_nxt = MODE_STANDBY;
    endcase
  end

  // outputs
  always_comb begin
    res.left_gun        = in_pulse && left_turn_nxt && cfg.left_enable;
    res.right_gun       = in_pulse && !left_turn_nxt && cfg.right_enable;
    res.gun_power       = fire_run || (mode_nxt == MODE_CAL);
    res.buzzer_on       = (beep_nxt != '0);
    res.armed_led       = (mode_nxt == MODE_STANDBY) && cfg.armed;
    res.activation_done = fire_end && !fire_abort && !cal_end;
    res.mode_now        = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STANDBY;
      run_r       <= '0;
      phase_r     <= '0;
      cycle_r     <= '0;
      left_turn_r <= 1'b0;
      beep_r      <= '0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      run_r       <= run_nxt;
      phase_r     <= phase_nxt;
      cycle_r     <= cycle_nxt;
      left_turn_r <= left_turn_nxt;
      beep_r      <= beep_nxt;
    end
  end

endmodule

[sv/alternating_pulse_firing_sequencer.sv]
`timescale 1ns / 1ps
// Alternating pulse firing sequencer, one input transfer per millisecond tick.
// Input channel (in_valid/in_ready/in_data): request code and trigger level.
// Output channel (out_valid/out_ready/out_data): gun drives, power, buzzer,
//   armed LED, activation pulse and the mode after the tick; one result per
//   input transfer, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle,
//   no wait states; write only while no tick is in flight.
// Datapath: an input transfer lands in the input register; when that stage
//   advances, the tick is evaluated against the mode/counter state and the
//   result is registered in the output register, which raises out_valid.
// Throughput: one tick per cycle while out_ready is high, set by the single state update per cycle.
// Stall: when out_ready is low the result register holds; the input register
//   still takes one more tick, after which in_ready drops until the result
//   is taken.
// Reset (rst_n low, synchronous): standby, counters and beep cleared,
//   configuration back to defaults, both channel stages empty.
module alternating_pulse_firing_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  apfs_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output apfs_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [apfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import apfs_pkg::*;

  cfg_t cfg;
  out_t res;
  in_t  s1_data_r;
  logic s1_valid_r, s1_valid_nxt;
  out_t out_data_r;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_xfer;

  apfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  apfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (s1_adv),
    .item  (s1_data_r),
    .res   (res)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_data_r <= in_data;
    if (s1_adv) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/apfs_checker.sv]
`timescale 1ns / 1ps

module apfs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input apfs_pkg::out_t out_data
);
  import apfs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_gun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.left_gun && out_data.right_gun))
    else $error("both guns driven");

  a_gun_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.left_gun || out_data.right_gun) |->
      out_data.gun_power && out_data.mode_now == MODE_FIRE)
    else $error("gun driven outside a firing run");

  a_act_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.activation_done |->
      out_data.mode_now == MODE_STANDBY && !out_data.gun_power &&
      !out_data.left_gun && !out_data.right_gun)
    else $error("activation pulse with outputs active");

  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.armed_led |-> out_data.mode_now == MODE_STANDBY)
    else $error("armed LED outside standby");

endmodule

bind alternating_pulse_firing_sequencer apfs_checker u_apfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
